/* design/jcc_pkg.sv */
package jcc_pkg;

   // last absolute day before year 1, month 1, day 1
   localparam logic [21:0] EPOCH_PREV = 22'd226894;
   // year start = 365 * y + floor((21 + 8 * y) / 33) + YEAR_BASE
   localparam logic [23:0] YEAR_BASE = 24'd226530;
   localparam logic [23:0] ABS_MAX = 24'd4194303;

   // reciprocal of 33, exact for numerators below 144631
   localparam logic [34:0] DIV33_MUL = 35'd127101;
   localparam int unsigned DIV33_SHIFT = 22;
   // 33 / 12053 scaled by 2^32, year estimate from day count
   localparam logic [45:0] EST_MUL = 46'd11759224;
   localparam int unsigned EST_SHIFT = 32;

   // command codes
   localparam logic CMD_TO_ABS = 1'b0;
   localparam logic CMD_TO_DATE = 1'b1;

   // result select codes
   localparam logic [1:0] RSP_ABS = 2'd0;
   localparam logic [1:0] RSP_DATE = 2'd1;
   localparam logic [1:0] RSP_EARLY = 2'd2;

   typedef struct packed {
      logic        command;
      logic [13:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [21:0] in_absolute;
   } jcc_req_type;

   typedef struct packed {
      logic [21:0] out_absolute;
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic        leap_year;
      logic        before_epoch;
   } jcc_rsp_type;

   typedef struct packed {
      logic       capture;
      logic       est;
      logic       init_year;
      logic       inc_year;
      logic       plus1;
      logic       load_rsp;
      logic [1:0] rsp_sel;
   } jcc_cmd_type;

   typedef struct packed {
      logic command;
      logic early;
      logic past;
   } jcc_status_type;

   // days in the months before month m of a year
   function automatic logic [8:0] month_sum(input logic [3:0] m, input logic leap);
      logic [8:0] s;
      case (m) inside
         4'd0, 4'd1: s = 9'd0;
         4'd2: s = 9'd31;
         4'd3: s = 9'd62;
         4'd4: s = 9'd93;
         4'd5: s = 9'd124;
         4'd6: s = 9'd155;
         4'd7: s = 9'd186;
         4'd8: s = 9'd216;
         4'd9: s = 9'd246;
         4'd10: s = 9'd276;
         4'd11: s = 9'd306;
         4'd12: s = 9'd336;
         default: s = 9'd365 + {8'b0, leap};
      endcase
      return s;
   endfunction

endpackage

/* design/jalaali_calendar_converter.sv */
// date to absolute day: one pass through the year start unit for the input year, then the result register
// absolute day to date: n year steps (1 to 3) past the
//   first year guess, each step one pass through the two-stage year start unit
// day before the epoch: flagged as before_epoch; one item in flight, result held in an output register
// synchronous active-high reset clears the sequencer and the result valid
module jalaali_calendar_converter
   import jcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  jcc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output jcc_rsp_type rsp_data
);

   jcc_cmd_type    cmd;
   jcc_status_type status;

   jcc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   jcc_datapath u_datapath (
      .clock (clock),
      .req   (req_data),
      .cmd   (cmd),
      .status(status),
      .rsp   (rsp_data)
   );

endmodule

/* design/jcc_ystart.sv */
module jcc_ystart
   import jcc_pkg::*;
(
   input  logic        clock,
   input  logic [14:0] yy,
   output logic [23:0] ys,
   output logic        leap
);

   logic [23:0] p365_ff, p365_in;
   logic [17:0] x_ff, x_in;
   logic [12:0] q_ff, q_in;
   logic [34:0] qm;
   logic [17:0] r;
   logic [23:0] ys_ff, ys_in;
   logic        leap_ff, leap_in;

   // stage one: 365 * y and (21 + 8 * y) / 33
   always_comb begin
      p365_in = 24'({9'b0, yy} * 24'd365);
      x_in = {yy, 3'b000} + 18'd21;
      qm = {17'b0, x_in} * DIV33_MUL;
      q_in = 13'(qm >> DIV33_SHIFT);
   end

   // stage two: year start sum, leap from the remainder
   always_comb begin
      r = x_ff - 18'({5'b0, q_ff} * 18'd33);
      leap_in = (r >= 18'd25);
      ys_in = p365_ff + {11'b0, q_ff} + YEAR_BASE;
   end

   always_ff @(posedge clock) begin
      p365_ff <= p365_in;
      x_ff <= x_in;
      q_ff <= q_in;
      ys_ff <= ys_in;
      leap_ff <= leap_in;
   end

   assign ys = ys_ff;
   assign leap = leap_ff;

endmodule

/* design/jcc_datapath.sv */
module jcc_datapath
   import jcc_pkg::*;
(
   input  logic           clock,
   input  jcc_req_type    req,
   input  jcc_cmd_type    cmd,
   output jcc_status_type status,
   output jcc_rsp_type    rsp
);

   logic        command_ff, command_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [21:0] date_ff, date_in;
   logic [13:0] est_ff, est_in;
   jcc_rsp_type rsp_ff, rsp_in;

   logic [21:0] dd;
   logic [45:0] est_prod;
   logic [23:0] ys;
   logic        leap;
   logic [23:0] abs_sum;
   logic [21:0] abs_sat;
   logic [8:0]  off, o2;
   logic [17:0] mprod;
   logic [3:0]  mq, r_month;
   logic [4:0]  r_day;

   // shared year start unit
   jcc_ystart u_ystart (
      .clock(clock),
      .yy   ({1'b0, year_ff} + {14'b0, cmd.plus1}),
      .ys   (ys),
      .leap (leap)
   );

   // first year guess, at most a few years low
   always_comb begin
      dd = date_ff - EPOCH_PREV;
      est_prod = {24'b0, dd} * EST_MUL;
      est_in = 14'(est_prod >> EST_SHIFT);
   end

   // input and year registers
   always_comb begin
      command_in = command_ff;
      month_in = month_ff;
      day_in = day_ff;
      date_in = date_ff;
      year_in = year_ff;
      if (cmd.capture) begin
         command_in = req.command;
         year_in = req.in_year;
         month_in = req.in_month;
         day_in = req.in_day;
         date_in = req.in_absolute;
      end else if (cmd.init_year) begin
         year_in = (est_ff >= 14'd2) ? est_ff - 14'd2 : 14'd0;
      end else if (cmd.inc_year) begin
         year_in = year_ff + 14'd1;
      end
   end

   // date to absolute day, saturating
   always_comb begin
      abs_sum = ys + {15'b0, month_sum(month_ff, leap)} + {19'b0, day_ff} - 24'd1;
      abs_sat = (abs_sum > ABS_MAX) ? ABS_MAX[21:0] : abs_sum[21:0];
   end

   // day of year to month and day
   always_comb begin
      off = 9'({2'b0, date_ff} - ys);
      o2 = off - 9'd186;
      mprod = 18'd0;
      mq = 4'd0;
      if (off < 9'd186) begin
         mprod = {9'b0, off} * 18'd265;
         mq = 4'(mprod >> 13);
         r_month = mq + 4'd1;
         r_day = 5'(off - 9'({5'b0, mq} * 9'd31) + 9'd1);
      end else if (off >= 9'd336) begin
         r_month = 4'd12;
         r_day = 5'(off - 9'd335);
      end else begin
         mprod = {9'b0, o2} * 18'd274;
         mq = 4'(mprod >> 13);
         r_month = mq + 4'd7;
         r_day = 5'(o2 - 9'({5'b0, mq} * 9'd30) + 9'd1);
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in = '0;
         case (cmd.rsp_sel)
            RSP_ABS: begin
               rsp_in.out_absolute = abs_sat;
               rsp_in.leap_year = leap;
            end
            RSP_DATE: begin
               rsp_in.out_year = year_ff;
               rsp_in.out_month = r_month;
               rsp_in.out_day = r_day;
               rsp_in.leap_year = leap;
            end
            default: begin
               rsp_in.before_epoch = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      year_ff <= year_in;
      month_ff <= month_in;
      day_ff <= day_in;
      date_ff <= date_in;
      if (cmd.est) begin
         est_ff <= est_in;
      end
      rsp_ff <= rsp_in;
   end

   assign status.command = command_ff;
   assign status.early = (date_ff <= EPOCH_PREV);
   assign status.past = ({2'b0, date_ff} >= ys);
   assign rsp = rsp_ff;

endmodule

/* design/jcc_ctrl.sv */
module jcc_ctrl
   import jcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  jcc_status_type status,
   output jcc_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_EST = 4'd2;
   localparam logic [3:0] S_INIT = 4'd3;
   localparam logic [3:0] S_Y0 = 4'd4;
   localparam logic [3:0] S_Y1 = 4'd5;
   localparam logic [3:0] S_YCHK = 4'd6;
   localparam logic [3:0] S_M0 = 4'd7;
   localparam logic [3:0] S_M1 = 4'd8;
   localparam logic [3:0] S_FIN_DATE = 4'd9;
   localparam logic [3:0] S_A0 = 4'd10;
   localparam logic [3:0] S_A1 = 4'd11;
   localparam logic [3:0] S_FIN_ABS = 4'd12;
   localparam logic [3:0] S_FIN_EARLY = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (status.command == CMD_TO_ABS) begin
               state_in = S_A0;
            end else if (status.early) begin
               state_in = S_FIN_EARLY;
            end else begin
               state_in = S_EST;
            end
         end
         S_EST: begin
            cmd.est = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init_year = 1'b1;
            state_in = S_Y0;
         end
         S_Y0: begin
            cmd.plus1 = 1'b1;
            state_in = S_Y1;
         end
         S_Y1: begin
            cmd.plus1 = 1'b1;
            state_in = S_YCHK;
         end
         S_YCHK: begin
            cmd.plus1 = 1'b1;
            if (status.past) begin
               cmd.inc_year = 1'b1;
               state_in = S_Y0;
            end else begin
               state_in = S_M0;
            end
         end
         S_M0: state_in = S_M1;
         S_M1: state_in = S_FIN_DATE;
         S_FIN_DATE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel = RSP_DATE;
               state_in = S_IDLE;
            end
         end
         S_A0: state_in = S_A1;
         S_A1: state_in = S_FIN_ABS;
         S_FIN_ABS: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel = RSP_ABS;
               state_in = S_IDLE;
            end
         end
         S_FIN_EARLY: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel = RSP_EARLY;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
